FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the box decode block.
// Standalone header; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is held.
`define DHBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dhbd assertion failed");

// Clocked assertion that also holds during reset.
`define DHBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dhbd assertion failed");

`endif

FILE: hw/rtl/dhbd_pkg.sv
// Package for the detection head box decode: register indexes, head codes,
// sigmoid table and interpolation, anchor and stride tables. No dependencies.
package dhbd_pkg;

    localparam int INPUT_SIZE = 640;

    localparam int GRID_P3 = INPUT_SIZE / 8;
    localparam int GRID_P4 = INPUT_SIZE / 16;
    localparam int GRID_P5 = INPUT_SIZE / 32;

    localparam int OUT_MIN = -524288;
    localparam int OUT_MAX = 524287;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_PAD_X     = 3'd1;
    localparam logic [2:0] CFG_PAD_Y     = 3'd2;
    localparam logic [2:0] CFG_INV_SCALE = 3'd3;
    localparam logic [2:0] CFG_HEAD_EN   = 3'd4;

    // head codes
    localparam logic [1:0] HEAD_P3 = 2'd0;
    localparam logic [1:0] HEAD_P4 = 2'd1;
    localparam logic [1:0] HEAD_P5 = 2'd2;

    localparam logic [1:0] ANCHOR_LAST = 2'd2;

    // logit lanes
    localparam int LANE_X   = 0;
    localparam int LANE_Y   = 1;
    localparam int LANE_W   = 2;
    localparam int LANE_H   = 3;
    localparam int LANE_OBJ = 4;
    localparam int LANE_CLS = 5;
    localparam int NUM_LANES = 6;

    typedef struct packed {
        logic       neg;
        logic [4:0] idx;
        logic [6:0] frac;
    } t_sig_in;

    function automatic logic [15:0] sig_tab(logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:  v = 16'd32768;
            5'd1:  v = 16'd40793;
            5'd2:  v = 16'd47911;
            5'd3:  v = 16'd53581;
            5'd4:  v = 16'd57724;
            5'd5:  v = 16'd60565;
            5'd6:  v = 16'd62428;
            5'd7:  v = 16'd63615;
            5'd8:  v = 16'd64357;
            5'd9:  v = 16'd64816;
            5'd10: v = 16'd65097;
            5'd11: v = 16'd65269;
            5'd12: v = 16'd65374;
            5'd13: v = 16'd65438;
            5'd14: v = 16'd65476;
            5'd15: v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

    // |x| clamped to 8.0, split into table index and fraction
    function automatic t_sig_in sig_prep(logic signed [15:0] x);
        logic [16:0] a;
        t_sig_in     p;
        a = x[15] ? 17'(-$signed({x[15], x})) : 17'({x[15], x});
        if (a > 17'd2048) begin
            a = 17'd2048;
        end
        p.neg  = x[15];
        p.idx  = a[11:7];
        p.frac = a[6:0];
        return p;
    endfunction

    function automatic logic [15:0] sig_eval(t_sig_in p);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] v;
        logic [19:0] prod;
        lo   = sig_tab(p.idx);
        hi   = sig_tab(p.idx + 5'd1);
        prod = 20'(hi - lo) * 20'(p.frac);
        if (p.idx >= 5'd16) begin
            v = sig_tab(5'd16);
        end else begin
            v = lo + 16'(prod[19:7]);
        end
        return p.neg ? 16'(17'd65536 - 17'(v)) : v;
    endfunction

    function automatic logic [2:0] stride_shift(logic [1:0] head);
        logic [2:0] s;
        case (head)
            HEAD_P3: s = 3'd3;
            HEAD_P4: s = 3'd4;
            default: s = 3'd5;
        endcase
        return s;
    endfunction

    function automatic logic [8:0] grid_size(logic [1:0] head);
        logic [8:0] g;
        case (head)
            HEAD_P3: g = 9'(GRID_P3);
            HEAD_P4: g = 9'(GRID_P4);
            default: g = 9'(GRID_P5);
        endcase
        return g;
    endfunction

    function automatic logic [8:0] anchor_w(logic [1:0] head, logic [1:0] anc);
        logic [8:0] w;
        case ({head, anc})
            {HEAD_P3, 2'd0}: w = 9'd10;
            {HEAD_P3, 2'd1}: w = 9'd16;
            {HEAD_P3, 2'd2}: w = 9'd33;
            {HEAD_P4, 2'd0}: w = 9'd30;
            {HEAD_P4, 2'd1}: w = 9'd62;
            {HEAD_P4, 2'd2}: w = 9'd59;
            {HEAD_P5, 2'd0}: w = 9'd116;
            {HEAD_P5, 2'd1}: w = 9'd156;
            {HEAD_P5, 2'd2}: w = 9'd373;
            default:         w = 9'd0;
        endcase
        return w;
    endfunction

    function automatic logic [8:0] anchor_h(logic [1:0] head, logic [1:0] anc);
        logic [8:0] h;
        case ({head, anc})
            {HEAD_P3, 2'd0}: h = 9'd13;
            {HEAD_P3, 2'd1}: h = 9'd30;
            {HEAD_P3, 2'd2}: h = 9'd23;
            {HEAD_P4, 2'd0}: h = 9'd61;
            {HEAD_P4, 2'd1}: h = 9'd45;
            {HEAD_P4, 2'd2}: h = 9'd119;
            {HEAD_P5, 2'd0}: h = 9'd90;
            {HEAD_P5, 2'd1}: h = 9'd198;
            {HEAD_P5, 2'd2}: h = 9'd326;
            default:         h = 9'd0;
        endcase
        return h;
    endfunction

endpackage

FILE: hw/rtl/detection_head_box_decode_top.sv
// Detection head box decode top level, seven register stages; uses dhbd_pkg.
// An accepted word passes stage registers 1 to 7 in order and is on the outputs with o_valid
// from stage 7; there is no backpressure on results.
// Throughput: one word per cycle; busy is low whenever reset is released.
// Reset (synchronous, active low) clears the stage valids and loads the register
// defaults; busy is high while reset is held.
module detection_head_box_decode_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_head,
    input  logic [1:0]         i_anchor,
    input  logic [6:0]         i_cell_x,
    input  logic [6:0]         i_cell_y,
    input  logic signed [15:0] i_logit_x,
    input  logic signed [15:0] i_logit_y,
    input  logic signed [15:0] i_logit_w,
    input  logic signed [15:0] i_logit_h,
    input  logic signed [15:0] i_logit_object,
    input  logic signed [15:0] i_logit_class,
    output logic               o_valid,
    output logic signed [19:0] o_left,
    output logic signed [19:0] o_top,
    output logic signed [19:0] o_right,
    output logic signed [19:0] o_bottom,
    output logic [15:0]        o_score
);

    // configuration
    logic [15:0] r_thr;
    logic [13:0] r_pad_x;
    logic [13:0] r_pad_y;
    logic [15:0] r_inv;
    logic [2:0]  r_head_en;

    // stage 1: checks, sigmoid operands
    logic                r_s1_v;
    logic [1:0]          r_s1_head;
    logic [1:0]          r_s1_anc;
    logic [6:0]          r_s1_cx;
    logic [6:0]          r_s1_cy;
    dhbd_pkg::t_sig_in   r_s1_sp [dhbd_pkg::NUM_LANES];
    // stage 2: sigmoids
    logic                r_s2_v;
    logic [1:0]          r_s2_head;
    logic [1:0]          r_s2_anc;
    logic [6:0]          r_s2_cx;
    logic [6:0]          r_s2_cy;
    logic [15:0]         r_s2_sig [dhbd_pkg::NUM_LANES];
    // stage 3: score product, squares, centres
    logic                r_s3_v;
    logic [31:0]         r_s3_prod;
    logic [31:0]         r_s3_sqw;
    logic [31:0]         r_s3_sqh;
    logic signed [31:0]  r_s3_ux;
    logic signed [31:0]  r_s3_uy;
    logic [8:0]          r_s3_aw;
    logic [8:0]          r_s3_ah;
    // stage 4: half sizes, threshold
    logic                r_s4_v;
    logic [15:0]         r_s4_score;
    logic [25:0]         r_s4_hw;
    logic [25:0]         r_s4_hh;
    logic signed [31:0]  r_s4_ux;
    logic signed [31:0]  r_s4_uy;
    // stage 5: corners (left, top, right, bottom)
    logic                r_s5_v;
    logic [15:0]         r_s5_score;
    logic signed [31:0]  r_s5_c [4];
    // stage 6: scaled corners
    logic                r_s6_v;
    logic [15:0]         r_s6_score;
    logic signed [48:0]  r_s6_p [4];
    // stage 7: outputs
    logic                r_s7_v;
    logic [15:0]         r_s7_score;
    logic signed [19:0]  r_s7_c [4];

    logic                accept;
    logic                n_s1_ok;
    logic [40:0]         n_s4_pw;
    logic [40:0]         n_s4_ph;
    logic                n_s4_pass;

    function automatic logic signed [31:0] f_centre(logic [15:0] s, logic [6:0] grid_pos,
                                                    logic [1:0] head, logic [13:0] pad);
        logic signed [31:0] base;
        logic signed [31:0] scaled;
        base   = $signed({15'd0, s, 1'b0}) - 32'sd32768 + $signed({9'd0, grid_pos, 16'd0});
        scaled = base <<< dhbd_pkg::stride_shift(head);
        return scaled - $signed({6'd0, pad, 12'd0});
    endfunction

    function automatic logic signed [19:0] f_sat(logic signed [48:0] p);
        logic signed [48:0] sh;
        logic signed [19:0] r;
        sh = p >>> 24;
        if (sh < 49'(dhbd_pkg::OUT_MIN)) begin
            r = 20'(dhbd_pkg::OUT_MIN);
        end else if (sh > 49'(dhbd_pkg::OUT_MAX)) begin
            r = 20'(dhbd_pkg::OUT_MAX);
        end else begin
            r = 20'(sh);
        end
        return r;
    endfunction

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_comb begin
        n_s1_ok = (i_head <= dhbd_pkg::HEAD_P5) && (i_anchor <= dhbd_pkg::ANCHOR_LAST)
               && r_head_en[i_head]
               && ({2'b00, i_cell_x} < dhbd_pkg::grid_size(i_head))
               && ({2'b00, i_cell_y} < dhbd_pkg::grid_size(i_head));
        n_s4_pw   = 41'(r_s3_sqw) * 41'(r_s3_aw);
        n_s4_ph   = 41'(r_s3_sqh) * 41'(r_s3_ah);
        n_s4_pass = r_s3_prod[31:16] > r_thr;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= 16'd16384;
            r_pad_x   <= 14'd0;
            r_pad_y   <= 14'd2240;
            r_inv     <= 16'd12288;
            r_head_en <= 3'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dhbd_pkg::CFG_THRESHOLD: r_thr     <= i_cfg_data;
                dhbd_pkg::CFG_PAD_X:     r_pad_x   <= i_cfg_data[13:0];
                dhbd_pkg::CFG_PAD_Y:     r_pad_y   <= i_cfg_data[13:0];
                dhbd_pkg::CFG_INV_SCALE: r_inv     <= i_cfg_data;
                dhbd_pkg::CFG_HEAD_EN:   r_head_en <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // stage valids; rejected words are dropped at entry, low scores at stage 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else begin
            r_s1_v <= accept & n_s1_ok;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v & n_s4_pass;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_s1_head <= i_head;
        r_s1_anc  <= i_anchor;
        r_s1_cx   <= i_cell_x;
        r_s1_cy   <= i_cell_y;
        r_s1_sp[dhbd_pkg::LANE_X]   <= dhbd_pkg::sig_prep(i_logit_x);
        r_s1_sp[dhbd_pkg::LANE_Y]   <= dhbd_pkg::sig_prep(i_logit_y);
        r_s1_sp[dhbd_pkg::LANE_W]   <= dhbd_pkg::sig_prep(i_logit_w);
        r_s1_sp[dhbd_pkg::LANE_H]   <= dhbd_pkg::sig_prep(i_logit_h);
        r_s1_sp[dhbd_pkg::LANE_OBJ] <= dhbd_pkg::sig_prep(i_logit_object);
        r_s1_sp[dhbd_pkg::LANE_CLS] <= dhbd_pkg::sig_prep(i_logit_class);

        r_s2_head <= r_s1_head;
        r_s2_anc  <= r_s1_anc;
        r_s2_cx   <= r_s1_cx;
        r_s2_cy   <= r_s1_cy;
        for (int k = 0; k < dhbd_pkg::NUM_LANES; k++) begin
            r_s2_sig[k] <= dhbd_pkg::sig_eval(r_s1_sp[k]);
        end

        r_s3_prod <= 32'(r_s2_sig[dhbd_pkg::LANE_OBJ]) * 32'(r_s2_sig[dhbd_pkg::LANE_CLS]);
        // (2s)^2 * anchor >> 17 equals s^2 * anchor >> 15
        r_s3_sqw  <= 32'(r_s2_sig[dhbd_pkg::LANE_W]) * 32'(r_s2_sig[dhbd_pkg::LANE_W]);
        r_s3_sqh  <= 32'(r_s2_sig[dhbd_pkg::LANE_H]) * 32'(r_s2_sig[dhbd_pkg::LANE_H]);
        r_s3_ux   <= f_centre(r_s2_sig[dhbd_pkg::LANE_X], r_s2_cx, r_s2_head, r_pad_x);
        r_s3_uy   <= f_centre(r_s2_sig[dhbd_pkg::LANE_Y], r_s2_cy, r_s2_head, r_pad_y);
        r_s3_aw   <= dhbd_pkg::anchor_w(r_s2_head, r_s2_anc);
        r_s3_ah   <= dhbd_pkg::anchor_h(r_s2_head, r_s2_anc);

        r_s4_score <= r_s3_prod[31:16];
        r_s4_hw    <= n_s4_pw[40:15];
        r_s4_hh    <= n_s4_ph[40:15];
        r_s4_ux    <= r_s3_ux;
        r_s4_uy    <= r_s3_uy;

        r_s5_score <= r_s4_score;
        r_s5_c[0]  <= r_s4_ux - $signed({6'd0, r_s4_hw});
        r_s5_c[1]  <= r_s4_uy - $signed({6'd0, r_s4_hh});
        r_s5_c[2]  <= r_s4_ux + $signed({6'd0, r_s4_hw});
        r_s5_c[3]  <= r_s4_uy + $signed({6'd0, r_s4_hh});

        r_s6_score <= r_s5_score;
        for (int k = 0; k < 4; k++) begin
            r_s6_p[k] <= 49'(r_s5_c[k]) * 49'($signed({1'b0, r_inv}));
        end

        r_s7_score <= r_s6_score;
        for (int k = 0; k < 4; k++) begin
            r_s7_c[k] <= f_sat(r_s6_p[k]);
        end
    end

    assign o_valid  = r_s7_v;
    assign o_left   = r_s7_c[0];
    assign o_top    = r_s7_c[1];
    assign o_right  = r_s7_c[2];
    assign o_bottom = r_s7_c[3];
    assign o_score  = r_s7_score;

endmodule

FILE: hw/rtl/dhbd_checker.sv
// Port-level checker for the box decode top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dhbd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [19:0] o_left,
    input logic signed [19:0] o_top,
    input logic signed [19:0] o_right,
    input logic signed [19:0] o_bottom,
    input logic [15:0]        o_score
);

    // busy only reflects reset
    `DHBD_ASSERT_ALWAYS(a_busy_rst, i_clk, busy == !i_rst_n)
    `DHBD_ASSERT_ALWAYS(a_rst_flush, i_clk, !i_rst_n |=> !o_valid)
    // every word out stems from an earlier word taken at the input
    `DHBD_ASSERT(a_latency, i_clk, i_rst_n, o_valid |-> $past(start && !busy, 7))
    `DHBD_ASSERT(a_box_order, i_clk, i_rst_n,
        o_valid |-> (o_left <= o_right) && (o_top <= o_bottom))
    // score must beat a threshold of at least zero
    `DHBD_ASSERT(a_score_nz, i_clk, i_rst_n, o_valid |-> o_score != 16'd0)

endmodule

bind detection_head_box_decode_top dhbd_checker u_dhbd_checker (.*);
